// ===== hdl/aac_pkg.sv =====
// ----------------------------------------------------------------------------
// aac_pkg
// Shared constants, types and helpers for the load adaptive admission control.
// ----------------------------------------------------------------------------
package aac_pkg;

    localparam int NUM_CONNS       = 64;
    localparam int NUM_FILER_CONNS = 8;
    localparam int AVG_SHIFT       = 3;

    localparam int FILER_N = (NUM_FILER_CONNS < NUM_CONNS) ? NUM_FILER_CONNS : NUM_CONNS;
    localparam int CONN_AW = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;

    localparam int ACT_W      = 3;
    localparam int IDX_W      = 8;
    localparam int LAT_W      = 48;
    localparam int LOAD_IN_W  = 8;
    localparam int DEC_W      = 2;
    localparam int CNT_W      = 16;
    localparam int LF_W       = 2;
    localparam int SLOW_CNT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [ACT_W-1:0] ACT_CONN_ADMIT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GLOBAL_ADMIT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START        = 3'd2;
    localparam logic [ACT_W-1:0] ACT_COMPLETE     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LOAD         = 3'd4;

    localparam logic [DEC_W-1:0] DEC_ADMIT  = 2'd0;
    localparam logic [DEC_W-1:0] DEC_QUEUE  = 2'd1;
    localparam logic [DEC_W-1:0] DEC_REJECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_CONN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESHOLD = 2'd2;

    localparam logic [LF_W-1:0]  LF_MAX    = 2'd3;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [SLOW_CNT_W-1:0] SLOW_CNT_MAX = '1;

    typedef struct packed {
        logic [CNT_W-1:0] in_flight;
        logic [LF_W-1:0]  load;
        logic [LAT_W-1:0] avg;
        logic             slow;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [DEC_W-1:0] dec;
        logic             wr;
        logic             is_complete;
        entry_t           entry;
        logic [CNT_W-1:0] gif_next;
    } calc_t;

    function automatic logic [CNT_W-1:0] scale_limit(input logic [CNT_W-1:0] lim,
                                                    input logic [LF_W-1:0]  lf);
        logic [CNT_W+1:0] t3;
        logic [CNT_W-1:0] m;
        t3 = {2'b00, lim} + {1'b0, lim, 1'b0};
        case (lf)
            2'd3:    m = {2'b00, lim[CNT_W-1:2]};
            2'd2:    m = {1'b0, lim[CNT_W-1:1]};
            2'd1:    m = t3[CNT_W+1:2];
            default: m = lim;
        endcase
        if (m == '0) begin
            m = CNT_W'(1);
        end
        return m;
    endfunction

    function automatic logic [DEC_W-1:0] over_limit(input logic [LF_W-1:0] lf);
        return (lf == LF_MAX) ? DEC_REJECT : DEC_QUEUE;
    endfunction

endpackage

// ===== hdl/aac_ram.sv =====
// ----------------------------------------------------------------------------
// aac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/aac_calc.sv =====
// ----------------------------------------------------------------------------
// aac_calc
// Per-item datapath: limit scaling, admit decision, counter, EWMA and load factor update.
// ----------------------------------------------------------------------------
module aac_calc (
    input  logic [aac_pkg::ACT_W-1:0]     action,
    input  logic [aac_pkg::LAT_W-1:0]     latency_ns,
    input  logic [aac_pkg::LOAD_IN_W-1:0] load_in,
    input  logic                          idx_ok,
    input  logic                          entry_ok,
    input  aac_pkg::entry_t               rd_entry,
    input  logic [aac_pkg::CNT_W-1:0]     global_limit,
    input  logic [aac_pkg::CNT_W-1:0]     per_conn_limit,
    input  logic [aac_pkg::CNT_W-1:0]     gif,
    input  logic [aac_pkg::LF_W-1:0]      max_filer_lf,
    output aac_pkg::calc_t                res
);
    import aac_pkg::*;

    entry_t           old_e;
    logic [CNT_W-1:0] m_conn;
    logic [CNT_W-1:0] m_glob;

    always_comb begin
        old_e  = entry_ok ? rd_entry : '0;
        m_conn = scale_limit(per_conn_limit, old_e.load);
        m_glob = scale_limit(global_limit, max_filer_lf);

        res             = '0;
        res.entry       = old_e;
        res.gif_next    = gif;
        res.dec         = DEC_ADMIT;
        res.is_complete = (action == ACT_COMPLETE);

        case (action)
            ACT_CONN_ADMIT: begin
                if (idx_ok && ((gif >= global_limit) || (old_e.in_flight >= m_conn))) begin
                    res.dec = over_limit(old_e.load);
                end
            end
            ACT_GLOBAL_ADMIT: begin
                if (gif >= m_glob) begin
                    res.dec = over_limit(max_filer_lf);
                end
            end
            ACT_START: begin
                if (idx_ok) begin
                    res.wr = 1'b1;
                    if (old_e.in_flight != CNT_MAX) begin
                        res.entry.in_flight = old_e.in_flight + CNT_W'(1);
                    end
                    if (gif != CNT_MAX) begin
                        res.gif_next = gif + CNT_W'(1);
                    end
                end
            end
            ACT_COMPLETE: begin
                if (idx_ok) begin
                    res.wr = 1'b1;
                    if (old_e.in_flight != '0) begin
                        res.entry.in_flight = old_e.in_flight - CNT_W'(1);
                    end
                    if (gif != '0) begin
                        res.gif_next = gif - CNT_W'(1);
                    end
                    res.entry.avg = old_e.avg - (old_e.avg >> AVG_SHIFT)
                                    + (latency_ns >> AVG_SHIFT);
                end
            end
            ACT_LOAD: begin
                if (idx_ok) begin
                    res.wr = 1'b1;
                    res.entry.load = (load_in > LOAD_IN_W'(LF_MAX)) ? LF_MAX
                                                                      : load_in[LF_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/load_adaptive_admission_control.sv =====
// ----------------------------------------------------------------------------
// load_adaptive_admission_control
// Connection admission control with load scaling and EWMA latency tracking.
// ----------------------------------------------------------------------------
// The connection table (in-flight count, load factor, latency average and slow
// flag per connection) lives in one RAM with a registered read. The RAM read
// is issued at acceptance, the next cycle computes the decision and the new
// entry from the read data, and the write-back state compares the new average
// with the slow threshold and writes the entry back while loading the result
// register. A stalled result register holds the item in its write-back state.
// Per-entry valid bits make the table read as zero after reset, so there is no
// clearing pass. The filer load factors are mirrored in flops, so a global
// admit needs no table read data.
module load_adaptive_admission_control (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [aac_pkg::ACT_W-1:0]        s_action,
    input  logic [aac_pkg::IDX_W-1:0]        s_conn_index,
    input  logic [aac_pkg::LAT_W-1:0]        s_latency_ns,
    input  logic [aac_pkg::LOAD_IN_W-1:0]    s_load_in,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [aac_pkg::DEC_W-1:0]        m_decision,
    output logic [aac_pkg::CNT_W-1:0]        m_conn_in_flight,
    output logic [aac_pkg::LF_W-1:0]         m_conn_load,
    output logic                             m_conn_is_slow,
    output logic [aac_pkg::CNT_W-1:0]        m_total_in_flight,
    output logic [aac_pkg::SLOW_CNT_W-1:0]   m_slow_count,

    input  logic                             cfg_wr_en,
    input  logic [aac_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [aac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import aac_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_WB} state_t;

    state_t                state_reg, state_next;

    logic [CNT_W-1:0]      glimit_reg;
    logic [CNT_W-1:0]      climit_reg;
    logic [LAT_W-1:0]      thr_reg;

    logic [ACT_W-1:0]      act_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [LAT_W-1:0]      lat_reg;
    logic [LOAD_IN_W-1:0]  lin_reg;
    logic                  idx_ok_reg;

    logic [CNT_W-1:0]      gif_reg;
    logic [SLOW_CNT_W-1:0] slow_cnt_reg, slow_cnt_next;
    logic                  vld_reg [NUM_CONNS];
    logic [LF_W-1:0]       filer_lf_reg [FILER_N];
    calc_t                 calc_reg;

    logic                  m_valid_reg;
    logic [DEC_W-1:0]      m_dec_reg;
    entry_t                m_entry_reg;
    logic [CNT_W-1:0]      m_total_reg;
    logic [SLOW_CNT_W-1:0] m_slow_cnt_reg;

    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;
    logic                  entry_ok;
    logic [LF_W-1:0]       max_lf;
    calc_t                 calc_res;
    logic                  now_slow;
    entry_t                wb_entry;
    logic                  has3, has2, has1;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_WB) && out_free;
    assign ram_we   = commit && calc_reg.wr;
    assign rd_entry = entry_t'(ram_rdata);
    assign entry_ok = idx_ok_reg && vld_reg[idx_reg[CONN_AW-1:0]];

    aac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CONNS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[CONN_AW-1:0]),
        .wdata (ENTRY_W'(wb_entry)),
        .re    (accept),
        .raddr (s_conn_index[CONN_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        has3 = 1'b0;
        has2 = 1'b0;
        has1 = 1'b0;
        for (int i = 0; i < FILER_N; i++) begin
            has3 |= (filer_lf_reg[i] == 2'd3);
            has2 |= (filer_lf_reg[i] == 2'd2);
            has1 |= (filer_lf_reg[i] == 2'd1);
        end
        max_lf = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));
    end

    aac_calc u_calc (
        .action         (act_reg),
        .latency_ns     (lat_reg),
        .load_in        (lin_reg),
        .idx_ok         (idx_ok_reg),
        .entry_ok       (entry_ok),
        .rd_entry       (rd_entry),
        .global_limit   (glimit_reg),
        .per_conn_limit (climit_reg),
        .gif            (gif_reg),
        .max_filer_lf   (max_lf),
        .res            (calc_res)
    );

    always_comb begin
        now_slow      = (calc_reg.entry.avg > thr_reg);
        wb_entry      = calc_reg.entry;
        slow_cnt_next = slow_cnt_reg;
        if (calc_reg.is_complete && idx_ok_reg) begin
            wb_entry.slow = now_slow;
            if (now_slow != calc_reg.entry.slow) begin
                if (now_slow) begin
                    if (slow_cnt_reg != SLOW_CNT_MAX) begin
                        slow_cnt_next = slow_cnt_reg + SLOW_CNT_W'(1);
                    end
                end else if (slow_cnt_reg != '0) begin
                    slow_cnt_next = slow_cnt_reg - SLOW_CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: state_next = ST_WB;
            ST_WB:   if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            gif_reg      <= '0;
            slow_cnt_reg <= '0;
            glimit_reg   <= CNT_W'(256);
            climit_reg   <= CNT_W'(64);
            thr_reg      <= LAT_W'(10000000);
            for (int i = 0; i < NUM_CONNS; i++) begin
                vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i < FILER_N; i++) begin
                filer_lf_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_GLOBAL_LIMIT:   glimit_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_PER_CONN_LIMIT: climit_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_SLOW_THRESHOLD: thr_reg    <= cfg_wdata[LAT_W-1:0];
                    default: ;
                endcase
            end

            if (commit) begin
                m_valid_reg  <= 1'b1;
                gif_reg      <= calc_reg.gif_next;
                slow_cnt_reg <= slow_cnt_next;
                if (calc_reg.wr) begin
                    vld_reg[idx_reg[CONN_AW-1:0]] <= 1'b1;
                end
                if (act_reg == ACT_LOAD && idx_ok_reg) begin
                    for (int i = 0; i < FILER_N; i++) begin
                        if (idx_reg == IDX_W'(i)) begin
                            filer_lf_reg[i] <= wb_entry.load;
                        end
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= s_action;
            idx_reg    <= s_conn_index;
            lat_reg    <= s_latency_ns;
            lin_reg    <= s_load_in;
            idx_ok_reg <= ({1'b0, s_conn_index} < (IDX_W + 1)'(NUM_CONNS));
        end
        if (state_reg == ST_CALC) begin
            calc_reg <= calc_res;
        end
        if (commit) begin
            m_dec_reg      <= calc_reg.dec;
            m_entry_reg    <= wb_entry;
            m_total_reg    <= calc_reg.gif_next;
            m_slow_cnt_reg <= slow_cnt_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_decision        = m_dec_reg;
    assign m_conn_in_flight  = m_entry_reg.in_flight;
    assign m_conn_load       = m_entry_reg.load;
    assign m_conn_is_slow    = m_entry_reg.slow;
    assign m_total_in_flight = m_total_reg;
    assign m_slow_count      = m_slow_cnt_reg;

`ifndef ASSERT_OFF
    a_ram_we_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_WB && out_free))
        else $error("table write outside write-back");

    a_accept_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CALC && !s_ready))
        else $error("accepted item did not enter calc");

    a_gif_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && gif_reg != $past(gif_reg)) |-> ($past(state_reg) == ST_WB))
        else $error("global count changed outside write-back");

    a_slow_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && slow_cnt_reg != $past(slow_cnt_reg))
            |-> ($past(state_reg) == ST_WB && $past(act_reg) == ACT_COMPLETE))
        else $error("slow count changed without a complete");

    a_mvalid_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_valid_reg)) |-> ($past(state_reg) == ST_WB))
        else $error("result raised without write-back");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for load_adaptive_admission_control. A directed table
// runs first from reset, then random request streams run under several limit
// and threshold settings and several sender and receiver idle patterns. Every
// accepted request is run through a local model of the connection table and
// the predicted (or typed) answer is compared field by field with the output.
// ----------------------------------------------------------------------------
module tb_top;
    import aac_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam logic [LAT_W-1:0] LAT_MAX     = '1;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [IDX_W-1:0]     conn;
        logic [LAT_W-1:0]     lat;
        logic [LOAD_IN_W-1:0] load_in;
    } request_t;

    typedef struct packed {
        logic [DEC_W-1:0]      decision;
        logic [CNT_W-1:0]      conn_in_flight;
        logic [LF_W-1:0]       conn_load;
        logic                  conn_is_slow;
        logic [CNT_W-1:0]      total_in_flight;
        logic [SLOW_CNT_W-1:0] slow_count;
    } answer_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        answer_t  ans;
    } row_t;

    localparam answer_t UNTYPED = '0;

    localparam int ROWS = 25;
    localparam row_t DIRECTED [ROWS] = '{
        '{'{ACT_CONN_ADMIT, 8'd0, 48'd0, 8'd0}, 1'b1,
          '{DEC_ADMIT, 16'd0, 2'd0, 1'b0, 16'd0, 8'd0}},
        '{'{ACT_GLOBAL_ADMIT, 8'd63, 48'd0, 8'd0}, 1'b1,
          '{DEC_ADMIT, 16'd0, 2'd0, 1'b0, 16'd0, 8'd0}},
        '{'{ACT_START, 8'd0, 48'd0, 8'd0}, 1'b1,
          '{DEC_ADMIT, 16'd1, 2'd0, 1'b0, 16'd1, 8'd0}},
        '{'{ACT_START, 8'd63, 48'd0, 8'd0}, 1'b1,
          '{DEC_ADMIT, 16'd1, 2'd0, 1'b0, 16'd2, 8'd0}},
        '{'{ACT_START, 8'd64, 48'd0, 8'd0}, 1'b1,
          '{DEC_ADMIT, 16'd0, 2'd0, 1'b0, 16'd2, 8'd0}},
        '{'{ACT_START, 8'd255, LAT_MAX, 8'd255}, 1'b1,
          '{DEC_ADMIT, 16'd0, 2'd0, 1'b0, 16'd2, 8'd0}},
        '{'{ACT_LOAD, 8'd0, 48'd0, 8'd255}, 1'b1,
          '{DEC_ADMIT, 16'd1, 2'd3, 1'b0, 16'd2, 8'd0}},
        '{'{ACT_CONN_ADMIT, 8'd0, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_GLOBAL_ADMIT, 8'd5, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_LOAD, 8'd7, 48'd0, 8'd1}, 1'b0, UNTYPED},
        '{'{ACT_LOAD, 8'd8, 48'd0, 8'd3}, 1'b0, UNTYPED},
        '{'{ACT_GLOBAL_ADMIT, 8'd200, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_COMPLETE, 8'd0, LAT_MAX, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_COMPLETE, 8'd0, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_COMPLETE, 8'd5, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_COMPLETE, 8'd63, 48'd80000008, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_COMPLETE, 8'd100, 48'd12345, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_CONN_ADMIT, 8'd100, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_LOAD, 8'd64, 48'd0, 8'd3}, 1'b0, UNTYPED},
        '{'{ACT_SPARE_5, 8'd0, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_SPARE_6, 8'd63, LAT_MAX, 8'd255}, 1'b0, UNTYPED},
        '{'{ACT_SPARE_7, 8'd255, 48'd0, 8'd0}, 1'b0, UNTYPED},
        '{'{ACT_LOAD, 8'd3, 48'd0, 8'd128}, 1'b0, UNTYPED},
        '{'{ACT_LOAD, 8'd0, 48'd0, 8'd2}, 1'b0, UNTYPED},
        '{'{ACT_CONN_ADMIT, 8'd63, 48'd0, 8'd0}, 1'b0, UNTYPED}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [ACT_W-1:0]      s_action;
    logic [IDX_W-1:0]      s_conn_index;
    logic [LAT_W-1:0]      s_latency_ns;
    logic [LOAD_IN_W-1:0]  s_load_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [DEC_W-1:0]      m_decision;
    logic [CNT_W-1:0]      m_conn_in_flight;
    logic [LF_W-1:0]       m_conn_load;
    logic                  m_conn_is_slow;
    logic [CNT_W-1:0]      m_total_in_flight;
    logic [SLOW_CNT_W-1:0] m_slow_count;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // local copy of the connection table and limits
    logic [CNT_W-1:0]      flight_cnt [NUM_CONNS];
    logic [LF_W-1:0]       load_fac [NUM_CONNS];
    logic [LAT_W-1:0]      lat_avg [NUM_CONNS];
    logic                  slow_flag [NUM_CONNS];
    logic [CNT_W-1:0]      total_flight;
    logic [SLOW_CNT_W-1:0] slow_total;
    logic [CNT_W-1:0]      cap_global;
    logic [CNT_W-1:0]      cap_conn;
    logic [LAT_W-1:0]      slow_thr;

    answer_t answers_due [$];
    int      mismatches = 0;
    int      gap_pct;
    int      stall_pct;
    int      hold_len;
    int      hold_used;

    load_adaptive_admission_control dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_conn_index      (s_conn_index),
        .s_latency_ns      (s_latency_ns),
        .s_load_in         (s_load_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_decision        (m_decision),
        .m_conn_in_flight  (m_conn_in_flight),
        .m_conn_load       (m_conn_load),
        .m_conn_is_slow    (m_conn_is_slow),
        .m_total_in_flight (m_total_in_flight),
        .m_slow_count      (m_slow_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned scaled_cap(input logic [CNT_W-1:0] lim,
                                               input logic [LF_W-1:0]  lf);
        int unsigned c;
        case (lf)
            2'd0:    c = lim;
            2'd1:    c = (int'(lim) * 3) / 4;
            2'd2:    c = lim / 2;
            default: c = lim / 4;
        endcase
        return (c == 0) ? 1 : c;
    endfunction

    function automatic logic [DEC_W-1:0] limit_answer(input logic [LF_W-1:0] lf);
        return (lf == LF_MAX) ? DEC_REJECT : DEC_QUEUE;
    endfunction

    function automatic answer_t admission_predict(input request_t r);
        answer_t          a;
        logic             ok;
        int               k;
        int               i;
        int unsigned      cap;
        logic [LF_W-1:0]  lf;
        logic [LAT_W-1:0] avg;
        logic             now_slow;
        a  = '0;
        k  = r.conn;
        ok = (k < NUM_CONNS);
        case (r.action)
            ACT_CONN_ADMIT: begin
                if (ok) begin
                    lf  = load_fac[k];
                    cap = scaled_cap(cap_conn, lf);
                    if (total_flight >= cap_global || flight_cnt[k] >= cap)
                        a.decision = limit_answer(lf);
                end
            end
            ACT_GLOBAL_ADMIT: begin
                lf = '0;
                for (i = 0; i < FILER_N; i++)
                    if (load_fac[i] > lf) lf = load_fac[i];
                if (total_flight >= scaled_cap(cap_global, lf))
                    a.decision = limit_answer(lf);
            end
            ACT_START: begin
                if (ok) begin
                    if (flight_cnt[k] != CNT_MAX) flight_cnt[k]++;
                    if (total_flight != CNT_MAX) total_flight++;
                end
            end
            ACT_COMPLETE: begin
                if (ok) begin
                    if (flight_cnt[k] != 0) flight_cnt[k]--;
                    if (total_flight != 0) total_flight--;
                    avg = lat_avg[k] - (lat_avg[k] >> AVG_SHIFT) + (r.lat >> AVG_SHIFT);
                    lat_avg[k] = avg;
                    now_slow = (avg > slow_thr);
                    if (now_slow != slow_flag[k]) begin
                        slow_flag[k] = now_slow;
                        if (now_slow && slow_total != SLOW_CNT_MAX) slow_total++;
                        else if (!now_slow && slow_total != 0) slow_total--;
                    end
                end
            end
            ACT_LOAD: begin
                if (ok)
                    load_fac[k] = (r.load_in > LOAD_IN_W'(LF_MAX)) ? LF_MAX
                                                                   : r.load_in[LF_W-1:0];
            end
            default: ;
        endcase
        if (ok) begin
            a.conn_in_flight = flight_cnt[k];
            a.conn_load      = load_fac[k];
            a.conn_is_slow   = slow_flag[k];
        end
        a.total_in_flight = total_flight;
        a.slow_count      = slow_total;
        return a;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(99);
        r.action = (pick < 30) ? ACT_START :
                   (pick < 55) ? ACT_COMPLETE :
                   (pick < 72) ? ACT_CONN_ADMIT :
                   (pick < 82) ? ACT_GLOBAL_ADMIT :
                   (pick < 96) ? ACT_LOAD :
                   ACT_W'($urandom_range(ACT_SPARE_7, ACT_SPARE_5));
        pick = $urandom_range(99);
        r.conn = (pick < 60) ? IDX_W'($urandom_range(FILER_N - 1)) :
                 (pick < 92) ? IDX_W'($urandom_range(NUM_CONNS - 1)) :
                 IDX_W'($urandom_range(255, NUM_CONNS));
        pick = $urandom_range(99);
        r.lat = (pick < 15) ? '0 :
                (pick < 80) ? LAT_W'($urandom_range(4000)) :
                (pick < 98) ? LAT_W'($urandom_range(40000)) :
                LAT_W'({$urandom(), $urandom()});
        r.load_in = ($urandom_range(99) < 70) ? LOAD_IN_W'($urandom_range(3))
                                              : LOAD_IN_W'($urandom());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    // called on a falling edge, returns on the falling edge after acceptance
    task automatic offer(input request_t r, input logic typed, input answer_t typed_ans);
        answer_t a;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= r.action;
        s_conn_index <= r.conn;
        s_latency_ns <= r.lat;
        s_load_in    <= r.load_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        a = admission_predict(r);
        answers_due.push_back(typed ? typed_ans : a);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] glim, input logic [CNT_W-1:0] clim,
                             input logic [LAT_W-1:0] thr);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_GLOBAL_LIMIT;
        cfg_wdata <= {32'($urandom()), glim};
        @(negedge aclk);
        cfg_addr  <= CFG_PER_CONN_LIMIT;
        cfg_wdata <= {32'($urandom()), clim};
        @(negedge aclk);
        cfg_addr  <= CFG_SLOW_THRESHOLD;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_wr_en  <= 1'b0;
        cap_global = glim;
        cap_conn   = clim;
        slow_thr   = thr;
    endtask

    task automatic run_phase(input int count, input int send_gap, input int recv_stall);
        int n;
        gap_pct   = send_gap;
        stall_pct = recv_stall;
        for (n = 0; n < count; n++) offer(random_request(), 1'b0, UNTYPED);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_used <= 0;
        end else if (hold_used < hold_len) begin
            m_ready   <= 1'b0;
            hold_used <= hold_used + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = answers_due.pop_front();
                if (m_decision !== want.decision)
                    report_mismatch("decision", m_decision, want.decision);
                if (m_conn_in_flight !== want.conn_in_flight)
                    report_mismatch("conn_in_flight", m_conn_in_flight, want.conn_in_flight);
                if (m_conn_load !== want.conn_load)
                    report_mismatch("conn_load", m_conn_load, want.conn_load);
                if (m_conn_is_slow !== want.conn_is_slow)
                    report_mismatch("conn_is_slow", m_conn_is_slow, want.conn_is_slow);
                if (m_total_in_flight !== want.total_in_flight)
                    report_mismatch("total_in_flight", m_total_in_flight,
                                    want.total_in_flight);
                if (m_slow_count !== want.slow_count)
                    report_mismatch("slow_count", m_slow_count, want.slow_count);
            end
        end
    end

    initial begin
        int k;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_action     = '0;
        s_conn_index = '0;
        s_latency_ns = '0;
        s_load_in    = '0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_len     = 0;
        cap_global   = 16'd256;
        cap_conn     = 16'd64;
        slow_thr     = 48'd10000000;
        total_flight = '0;
        slow_total   = '0;
        for (k = 0; k < NUM_CONNS; k++) begin
            flight_cnt[k] = '0;
            load_fac[k]   = '0;
            lat_avg[k]    = '0;
            slow_flag[k]  = 1'b0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < ROWS; k++)
            offer(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].ans);

        configure(16'd12, 16'd4, 48'd1000);
        run_phase(400, 0, 0);
        configure(16'hFFFF, 16'hFFFF, LAT_MAX);
        run_phase(200, 81, 0);
        configure(16'd1, 16'd1, 48'd0);
        run_phase(250, 0, 81);
        configure(16'd0, 16'd3, 48'd500);
        run_phase(200, 33, 33);

        // long receiver hold while the sender keeps pushing: input must stall
        configure(16'd20, 16'd6, 48'd2000);
        hold_len = 300;
        run_phase(60, 0, 0);
        run_phase(400, 33, 33);

        configure(16'd8, 16'd2, 48'd1500);
        run_phase(450, 0, 0);

        drain();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
